// ===== design/barometric_pressure_compensation_top_macros.svh =====
// Assertion macros for the pressure compensation block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bpc_pkg.sv =====
// Shared constants and arithmetic helpers for the pressure compensation block.
package bpc_pkg;

  localparam int DivWidth = 32;
  localparam int DivStages = DivWidth;
  localparam int NumRegs = 5;
  localparam int AddrWidth = 5;

  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2 = 3'd3;
  localparam logic [2:0] RegMcMd = 3'd4;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] B4Bias = 32'd32768;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] CoefSq = 32'd3038;
  localparam logic [31:0] CoefLin = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] CoefOfs = 32'd3791;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

endpackage

// ===== design/barometric_pressure_compensation_top.sv =====
// Top level: calibration registers and the pipelined compensation datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  input     | in_valid / in_ready    | raw_temperature, raw_pressure, oversampling
//  output    | out_valid / out_ready  | temperature_tenths, pressure_pa, divide_error
//  config    | psel/penable/pready    | paddr, pwdata, prdata
//
// One request per cycle while the output is not stalled; the path runs through the two
// 32-stage dividers plus the multiply stages around them.
// Reset clears valid bits and calibration registers; no clearing pass.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module barometric_pressure_compensation_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    raw_temperature,
  input  logic [18:0]                    raw_pressure,
  input  logic [1:0]                     oversampling,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             temperature_tenths,
  output logic signed [31:0]             pressure_pa,
  output logic                           divide_error,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpc_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  typedef struct packed {
    logic        valid;
    logic [18:0] up;
    logic [1:0]  oss;
    logic [31:0] x1;
    logic        err;
    logic        neg;
  } side1_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] t;
    logic        err;
    logic        dbl;
  } side2_t;

  // ---------------- configuration ----------------
  logic [31:0] cal [bpc_pkg::NumRegs];
  logic [2:0]  reg_idx;
  logic        wr;

  assign reg_idx = paddr[4:2];
  assign wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bpc_pkg::NumRegs; k++) cal[k] <= '0;
    end else if (wr && reg_idx < 3'(bpc_pkg::NumRegs)) begin
      cal[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < 3'(bpc_pkg::NumRegs)) prdata = cal[reg_idx];
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(cal[bpc_pkg::RegAc1Ac2][31:16]);
  assign ac2 = bpc_pkg::sx16(cal[bpc_pkg::RegAc1Ac2][15:0]);
  assign ac3 = bpc_pkg::sx16(cal[bpc_pkg::RegAc3Ac4][31:16]);
  assign ac4 = {16'd0, cal[bpc_pkg::RegAc3Ac4][15:0]};
  assign ac5 = {16'd0, cal[bpc_pkg::RegAc5Ac6][31:16]};
  assign ac6 = {16'd0, cal[bpc_pkg::RegAc5Ac6][15:0]};
  assign b1  = bpc_pkg::sx16(cal[bpc_pkg::RegB1B2][31:16]);
  assign b2  = bpc_pkg::sx16(cal[bpc_pkg::RegB1B2][15:0]);
  assign mc  = bpc_pkg::sx16(cal[bpc_pkg::RegMcMd][31:16]);
  assign md  = bpc_pkg::sx16(cal[bpc_pkg::RegMcMd][15:0]);

  // ---------------- pipeline control ----------------
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- temperature front ----------------
  logic        v0, v1, v2, v3;
  logic [15:0] ut0;
  logic [18:0] up0, up1, up2, up3;
  logic [1:0]  oss0, oss1, oss2, oss3;
  logic [31:0] prod1, x1_2, den2, x1_3, num3, dvs3;
  logic        dz3, neg3;
  logic [31:0] num2;

  assign num2 = {mc[20:0], 11'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid; v1 <= v0; v2 <= v1; v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ut0 <= raw_temperature; up0 <= raw_pressure; oss0 <= oversampling;
      up1 <= up0; oss1 <= oss0;
      prod1 <= bpc_pkg::mul32(32'({16'd0, ut0} - ac6), ac5);
      up2 <= up1; oss2 <= oss1;
      x1_2 <= bpc_pkg::asr32(prod1, 15);
      den2 <= 32'(bpc_pkg::asr32(prod1, 15) + md);
      up3 <= up2; oss3 <= oss2; x1_3 <= x1_2;
      dz3 <= den2 == '0;
      neg3 <= num2[31] ^ den2[31];
      num3 <= num2[31] ? 32'(-num2) : num2;
      dvs3 <= den2[31] ? 32'(-den2) : den2;
    end
  end

  // ---------------- divider 1: X2 = (MC<<11)/(X1+MD) ----------------
  logic [31:0] q1;
  side1_t      dl1 [bpc_pkg::DivStages];
  side1_t      s1_in, s1_out;

  bpc_div u_div_t (.clk(clk), .en(en), .dividend(num3), .divisor(dvs3), .quotient(q1));

  assign s1_in = '{valid: v3, up: up3, oss: oss3, x1: x1_3, err: dz3, neg: neg3};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bpc_pkg::DivStages; k++) dl1[k].valid <= 1'b0;
    end else if (en) begin
      dl1[0] <= s1_in;
      for (int k = 1; k < bpc_pkg::DivStages; k++) dl1[k] <= dl1[k-1];
    end
  end
  assign s1_out = dl1[bpc_pkg::DivStages-1];

  // ---------------- pressure coefficient stages ----------------
  logic        v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic        e4, e5, e6, e7, e8, e9, e10, e11, e12, e13;
  logic [18:0] up4, up5, up6, up7, up8, up9, up10;
  logic [1:0]  os4, os5, os6, os7, os8, os9, os10, os11;
  logic [15:0] t5, t6, t7, t8, t9, t10, t11, t12, t13;
  logic [31:0] b5_4, b6_5, sqr6, a2b6, a3b6, sq7, a2_7, a3_7, m2_8, m1_8, a2_8, a3_8;
  logic [31:0] x3a9, x3b9, b3_10, b4p10, b4_11, diff11, b4_12, b7_12, dvd13, dvs13;
  logic        dbl13;
  logic [31:0] x2_4, tsh;

  assign x2_4 = s1_out.neg ? 32'(-q1) : q1;
  assign tsh = bpc_pkg::asr32(32'(b5_4 + 32'd8), 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0; v13 <= 1'b0;
    end else if (en) begin
      v4 <= s1_out.valid; v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
      v9 <= v8; v10 <= v9; v11 <= v10; v12 <= v11; v13 <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e4 <= s1_out.err; up4 <= s1_out.up; os4 <= s1_out.oss;
      b5_4 <= 32'(s1_out.x1 + x2_4);

      e5 <= e4; up5 <= up4; os5 <= os4;
      b6_5 <= 32'(b5_4 - bpc_pkg::TempOffset);
      if ($signed(tsh) > 32'sd32767) t5 <= 16'h7FFF;
      else if ($signed(tsh) < -32'sd32768) t5 <= 16'h8000;
      else t5 <= tsh[15:0];

      e6 <= e5; up6 <= up5; os6 <= os5; t6 <= t5;
      sqr6 <= bpc_pkg::mul32(b6_5, b6_5);
      a2b6 <= bpc_pkg::mul32(ac2, b6_5);
      a3b6 <= bpc_pkg::mul32(ac3, b6_5);

      e7 <= e6; up7 <= up6; os7 <= os6; t7 <= t6;
      sq7 <= bpc_pkg::asr32(sqr6, 12);
      a2_7 <= bpc_pkg::asr32(a2b6, 11);
      a3_7 <= bpc_pkg::asr32(a3b6, 13);

      e8 <= e7; up8 <= up7; os8 <= os7; t8 <= t7;
      m2_8 <= bpc_pkg::mul32(b2, sq7);
      m1_8 <= bpc_pkg::mul32(b1, sq7);
      a2_8 <= a2_7; a3_8 <= a3_7;

      e9 <= e8; up9 <= up8; os9 <= os8; t9 <= t8;
      x3a9 <= 32'(bpc_pkg::asr32(m2_8, 11) + a2_8);
      x3b9 <= bpc_pkg::asr32(32'(a3_8 + bpc_pkg::asr32(m1_8, 16) + 32'd2), 2);

      e10 <= e9; up10 <= up9; os10 <= os9; t10 <= t9;
      b3_10 <= bpc_pkg::asr32(
                 32'((32'(bpc_pkg::mul32(ac1, 32'd4) + x3a9) << os9) + 32'd2), 2);
      b4p10 <= bpc_pkg::mul32(ac4, 32'(x3b9 + bpc_pkg::B4Bias));

      os11 <= os10; t11 <= t10;
      b4_11 <= b4p10 >> 15;
      e11 <= e10 || ((b4p10 >> 15) == '0);
      diff11 <= 32'({13'd0, up10} - b3_10);

      e12 <= e11; t12 <= t11; b4_12 <= b4_11;
      b7_12 <= bpc_pkg::mul32(diff11, bpc_pkg::PressScale >> os11);

      e13 <= e12; t13 <= t12;
      dbl13 <= b7_12[31];
      dvd13 <= b7_12[31] ? b7_12 : {b7_12[30:0], 1'b0};
      dvs13 <= b4_12;
    end
  end

  // ---------------- divider 2: p = B7/B4 ----------------
  logic [31:0] q2;
  side2_t      dl2 [bpc_pkg::DivStages];
  side2_t      s2_in, s2_out;

  bpc_div u_div_p (.clk(clk), .en(en), .dividend(dvd13), .divisor(dvs13), .quotient(q2));

  assign s2_in = '{valid: v13, t: t13, err: e13, dbl: dbl13};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bpc_pkg::DivStages; k++) dl2[k].valid <= 1'b0;
    end else if (en) begin
      dl2[0] <= s2_in;
      for (int k = 1; k < bpc_pkg::DivStages; k++) dl2[k] <= dl2[k-1];
    end
  end
  assign s2_out = dl2[bpc_pkg::DivStages-1];

  // ---------------- pressure correction ----------------
  logic        v14, v15, v16;
  logic        e14, e15, e16;
  logic [15:0] t14, t15, t16;
  logic [31:0] p14, p15, p16, m1_15, m2_15, m3_16, x2_16, ps14, pfin;

  assign ps14 = bpc_pkg::asr32(p14, 8);
  assign pfin = 32'(p16 + bpc_pkg::asr32(
                  32'(bpc_pkg::asr32(m3_16, 16) + x2_16 + bpc_pkg::CoefOfs), 4));

  always_ff @(posedge clk) begin
    if (rst) begin
      v14 <= 1'b0; v15 <= 1'b0; v16 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v14 <= s2_out.valid; v15 <= v14; v16 <= v15; out_valid <= v16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e14 <= s2_out.err; t14 <= s2_out.t;
      p14 <= s2_out.dbl ? {q2[30:0], 1'b0} : q2;

      e15 <= e14; t15 <= t14; p15 <= p14;
      m1_15 <= bpc_pkg::mul32(ps14, ps14);
      m2_15 <= bpc_pkg::mul32(bpc_pkg::CoefLin, p14);

      e16 <= e15; t16 <= t15; p16 <= p15;
      m3_16 <= bpc_pkg::mul32(m1_15, bpc_pkg::CoefSq);
      x2_16 <= bpc_pkg::asr32(m2_15, 16);

      divide_error <= e16;
      temperature_tenths <= e16 ? '0 : $signed(t16);
      pressure_pa <= e16 ? '0 : $signed(pfin);
    end
  end

  // ---------------- checks ----------------
`include "barometric_pressure_compensation_top_macros.svh"

  `BPC_ASSERT_NOW(a_err_zero, out_valid && divide_error, temperature_tenths == '0 && pressure_pa == '0, "error result not zero")
  `BPC_ASSERT_NEXT(a_stall_hold, !en && v16, v16 && out_valid, "pipeline moved during stall")
  `BPC_ASSERT_NEXT(a_div_align, en && v13, dl2[0].valid, "divider side data lost valid")

endmodule

// ===== design/bpc_div.sv =====
// Pipelined unsigned 32/32 divider, one quotient bit per stage.
module bpc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);

  logic [31:0] rem [bpc_pkg::DivStages];
  logic [31:0] num [bpc_pkg::DivStages];
  logic [31:0] dvs [bpc_pkg::DivStages];
  logic [31:0] quo [bpc_pkg::DivStages];

  genvar i;
  generate
    for (i = 0; i < bpc_pkg::DivStages; i++) begin : g_stage
      logic [31:0] rin, nin, din, qin;
      logic [32:0] trial;
      logic        take;

      if (i == 0) begin : g_first
        assign rin = '0;
        assign nin = dividend;
        assign din = divisor;
        assign qin = '0;
      end else begin : g_next
        assign rin = rem[i-1];
        assign nin = num[i-1];
        assign din = dvs[i-1];
        assign qin = quo[i-1];
      end

      assign trial = {rin, nin[31]};
      assign take = trial >= {1'b0, din};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= take ? 32'(trial - {1'b0, din}) : trial[31:0];
          num[i] <= {nin[30:0], 1'b0};
          dvs[i] <= din;
          quo[i] <= {qin[30:0], take};
        end
      end
    end
  endgenerate

  assign quotient = quo[bpc_pkg::DivStages-1];

endmodule
